// ----- design/ddmd_pkg.sv -----
package ddmd_pkg;

	localparam int FRAME_PIXELS = 25;
	localparam int PIX_IDX_W = $clog2(FRAME_PIXELS);
	localparam logic [PIX_IDX_W-1:0] LAST_PIX_IDX = PIX_IDX_W'(FRAME_PIXELS - 1);

	localparam int DIGIT_W = 4;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	localparam int NUM_GLYPHS = 10;

	localparam logic [7:0] LIT_LEVEL = 8'd255;
	localparam logic [31:0] LIT_WORD = {8'h00, LIT_LEVEL, 16'h0000};
	localparam logic [31:0] DEBOUNCE_RESET = 32'd200;

	localparam int PADDR_W = 3;
	localparam logic CFG_DEBOUNCE_IDX = 1'b0;

	localparam logic REQ_INC = 1'b0;
	localparam logic REQ_DEC = 1'b1;

	typedef logic [FRAME_PIXELS-1:0] glyph_t;

	// Written in row order, so bit 0 holds the bottom-right pixel, which is sent first.
	localparam glyph_t GLYPHS [NUM_GLYPHS] = '{
		25'b11111_10001_10001_10001_11111,
		25'b00100_01100_10100_00100_11111,
		25'b11111_00001_11111_10000_11111,
		25'b11111_00001_01111_00001_11111,
		25'b10011_10011_11111_00011_00011,
		25'b11111_10000_11111_00001_11111,
		25'b11111_10000_11111_10001_11111,
		25'b11111_00001_00110_00100_01000,
		25'b11111_10001_11111_10001_11111,
		25'b11111_10001_11111_00001_11111
	};

	typedef struct packed {
		logic        req_type;
		logic [31:0] time_ms;
	} press_t;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic        last_pixel;
	} pixel_t;

endpackage

// ----- design/debounced_digit_matrix_driver_core.sv -----
// Debounced digit matrix driver.
// Press channel: press_valid / press_stall carry one button press (increment or
// decrement) with its millisecond timestamp. A press is kept only when the time
// since the last kept press, modulo 2^32, exceeds the debounce window.
// Pixel channel: pixel_valid / pixel_stall carry 25 GRB words for the 5x5 glyph
// of the new digit, the last one flagged by last_pixel.
// A press is held in the input register until it is judged; its first pixel is
// presented the cycle after it is kept. Pixels leave the output shift register
// one per cycle while pixel_stall is low; a rejected press leaves without waiting.
// A press waiting behind a frame is judged as soon as the frame's last pixel
// transfer completes, so frames follow one another without a gap.
// Reset clears the digit to 0, the last press time to 0 and the window to 200 ms.
// When the receiver stalls, the current pixel holds. press_stall is high while a
// press that passes the window waits in the input register behind a frame.
// The debounce window is written over the APB port at byte address 0.
module debounced_digit_matrix_driver_core
	import ddmd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               press_valid,
	output logic               press_stall,
	input  press_t             press,
	output logic               pixel_valid,
	input  logic               pixel_stall,
	output pixel_t             pixel,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0]          debounce_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic [31:0]          last_time_q;

	logic                 valid_s1;
	press_t               press_s1;

	logic                 busy_q;
	glyph_t               shift_q;
	logic [PIX_IDX_W-1:0] pix_idx_q;

	logic                 cfg_wr;
	logic [31:0]          elapsed;
	logic                 pass;
	logic                 pix_xfer;
	logic                 frame_end;
	logic                 can_load;
	logic                 load;
	logic                 s1_done;
	logic [DIGIT_W-1:0]   digit_next;
	logic [DIGIT_W-1:0]   glyph_sel;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_DEBOUNCE_IDX);
	assign prdata = (paddr[2] == CFG_DEBOUNCE_IDX) ? debounce_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_wr) begin
			debounce_q <= pwdata;
		end
	end

	// Judge the registered press against the state left by the previous one.
	assign elapsed = press_s1.time_ms - last_time_q;
	assign pass    = elapsed > debounce_q;

	always_comb begin
		digit_next = digit_q;
		if (press_s1.req_type == REQ_INC) begin
			if (digit_q < DIGIT_MAX) begin
				digit_next = digit_q + 4'd1;
			end
		end else begin
			if (digit_q != '0) begin
				digit_next = digit_q - 4'd1;
			end
		end
		glyph_sel = (digit_next > DIGIT_MAX) ? DIGIT_MAX : digit_next;
	end

	assign pix_xfer    = busy_q && !pixel_stall;
	assign frame_end   = pix_xfer && (pix_idx_q == LAST_PIX_IDX);
	assign can_load    = !busy_q || frame_end;
	assign load        = valid_s1 && pass && can_load;
	assign s1_done     = valid_s1 && (!pass || can_load);
	assign press_stall = valid_s1 && !s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (press_valid && !press_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (press_valid && !press_stall) begin
			press_s1 <= press;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q     <= '0;
			last_time_q <= '0;
		end else if (load) begin
			digit_q     <= digit_next;
			last_time_q <= press_s1.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pix_idx_q <= '0;
		end else if (load) begin
			busy_q    <= 1'b1;
			pix_idx_q <= '0;
		end else if (frame_end) begin
			busy_q    <= 1'b0;
		end else if (pix_xfer) begin
			pix_idx_q <= pix_idx_q + PIX_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= GLYPHS[glyph_sel];
		end else if (pix_xfer) begin
			shift_q <= shift_q >> 1;
		end
	end

	assign pixel_valid      = busy_q;
	assign pixel.pixel_word = shift_q[0] ? LIT_WORD : 32'd0;
	assign pixel.last_pixel = (pix_idx_q == LAST_PIX_IDX);

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q <= DIGIT_MAX)
		else $error("digit left its range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pix_idx_q <= LAST_PIX_IDX)
		else $error("pixel index beyond the frame");

	a_load_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> pixel_valid && pix_idx_q == '0)
		else $error("kept press did not start a frame");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		press_stall |-> valid_s1 && pass && busy_q)
		else $error("press stalled without a frame in progress");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !pass) |=> $stable(last_time_q) && $stable(digit_q))
		else $error("rejected press changed the state");

endmodule

// ----- tb/debounced_digit_matrix_driver_core_tb.sv -----
`timescale 1ns / 1ps

localparam logic [31:0] LIT_PIXEL_WORD = 32'h00FF_0000;
localparam int FRAME_LEN = 25;
localparam logic [3:0] TOP_DIGIT = 4'd9;

// Keeps its own copy of the digit, the last kept press time and the window, and
// holds the pixels that the kept presses are still owed.
class frame_tracker;
	logic [31:0] window_ms;
	logic [31:0] last_ms;
	logic [3:0] digit;
	ddmd_pkg::pixel_t owed_pixels[$];
	int unsigned errors;

	function new();
		window_ms = 32'd200;
		last_ms = 32'd0;
		digit = 4'd0;
		errors = 0;
	endfunction

	// Row order, first entry in the top bit, so bit i is the i-th pixel sent.
	function logic [24:0] font_rows(input logic [3:0] d);
		case (d)
			4'd0: return 25'b11111_10001_10001_10001_11111;
			4'd1: return 25'b00100_01100_10100_00100_11111;
			4'd2: return 25'b11111_00001_11111_10000_11111;
			4'd3: return 25'b11111_00001_01111_00001_11111;
			4'd4: return 25'b10011_10011_11111_00011_00011;
			4'd5: return 25'b11111_10000_11111_00001_11111;
			4'd6: return 25'b11111_10000_11111_10001_11111;
			4'd7: return 25'b11111_00001_00110_00100_01000;
			4'd8: return 25'b11111_10001_11111_10001_11111;
			default: return 25'b11111_10001_11111_00001_11111;
		endcase
	endfunction

	function void set_window(input logic [31:0] w);
		window_ms = w;
	endfunction

	function int pending();
		return owed_pixels.size();
	endfunction

	function void note_press(input ddmd_pkg::press_t p);
		logic [31:0] since;
		logic [24:0] rows;
		ddmd_pkg::pixel_t px;
		since = p.time_ms - last_ms;
		if (since <= window_ms)
			return;
		if (p.req_type == ddmd_pkg::REQ_INC) begin
			if (digit < TOP_DIGIT)
				digit++;
		end else if (digit > 4'd0) begin
			digit--;
		end
		last_ms = p.time_ms;
		rows = font_rows(digit);
		for (int i = 0; i < FRAME_LEN; i++) begin
			px.pixel_word = rows[i] ? LIT_PIXEL_WORD : 32'd0;
			px.last_pixel = (i == FRAME_LEN - 1);
			owed_pixels.push_back(px);
		end
	endfunction

	function void check_pixel(input ddmd_pkg::pixel_t got);
		ddmd_pkg::pixel_t want;
		if (owed_pixels.size() == 0) begin
			$error("pixel transfer with no frame owed: pixel_word %h last_pixel %b",
				got.pixel_word, got.last_pixel);
			errors++;
			return;
		end
		want = owed_pixels.pop_front();
		if (got.pixel_word !== want.pixel_word) begin
			$error("pixel_word: expected %h, actual %h", want.pixel_word, got.pixel_word);
			errors++;
		end
		if (got.last_pixel !== want.last_pixel) begin
			$error("last_pixel: expected %b, actual %b", want.last_pixel, got.last_pixel);
			errors++;
		end
	endfunction
endclass

module debounced_digit_matrix_driver_core_tb;
	import ddmd_pkg::*;

	localparam logic [PADDR_W-1:0] DEBOUNCE_ADDR = PADDR_W'(4 * CFG_DEBOUNCE_IDX);
	localparam int HOLD_CYCLES = 250;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic press_valid;
	logic press_stall;
	press_t press_item;
	logic pixel_valid;
	logic pixel_stall;
	pixel_t pixel_item;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	frame_tracker sb;
	bit idle_en;
	bit hold_req;
	int hold_left;
	int quiet_cycles;

	debounced_digit_matrix_driver_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.press_valid(press_valid),
		.press_stall(press_stall),
		.press(press_item),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pixel receiver: checks each transfer, then picks the next cycle's stall.
	always @(posedge clk) begin
		if (arst_n && pixel_valid === 1'b1 && pixel_stall === 1'b0)
			sb.check_pixel(pixel_item);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			pixel_stall <= 1'b1;
			hold_left--;
		end else begin
			pixel_stall <= idle_en && ($urandom_range(99, 0) < 10);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (press_valid && press_stall === 1'b0) ||
				(pixel_valid === 1'b1 && !pixel_stall) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL debounced_digit_matrix_driver_core");
				$finish;
			end
		end
	end

	// Writes the window, reads it straight back and keeps the predictor in step.
	task automatic cfg_write_debounce(input logic [31:0] w);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DEBOUNCE_ADDR;
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_window(w);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== w) begin
			$error("debounce_ms: expected %h, actual %h", w, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offers one press and holds it until the transfer; valid stays high only
	// when the next press follows without a gap.
	task automatic send_press(input logic req, input logic [31:0] stamp);
		press_t p;
		int unsigned gap;
		p.req_type = req;
		p.time_ms = stamp;
		press_item <= p;
		press_valid <= 1'b1;
		do @(posedge clk); while (press_stall !== 1'b0);
		sb.note_press(p);
		gap = (idle_en && $urandom_range(99, 0) < 10) ? $urandom_range(12, 1) : 0;
		if (gap != 0) begin
			press_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_frames_done();
		press_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// A rejected press may still be in the input register.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly presses past the window, the rest contact bounce or any time at all.
	task automatic random_press(input int good_pct);
		logic [63:0] span;
		logic [31:0] stamp;
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < good_pct) begin
			span = {32'd0, sb.window_ms} + 64'd1 + 64'($urandom_range(600, 0));
			if (span > 64'hFFFF_FFFF)
				span = 64'hFFFF_FFFF;
			stamp = sb.last_ms + span[31:0];
		end else if (pick < good_pct + (100 - good_pct) / 2) begin
			stamp = sb.last_ms + 32'($urandom_range(sb.window_ms, 0));
		end else begin
			stamp = $urandom();
		end
		send_press(1'($urandom_range(1, 0)), stamp);
	endtask

	task automatic run_phase(input logic [31:0] w, input int items, input int good_pct,
			input bit idle, input bit hold);
		wait_frames_done();
		cfg_write_debounce(w);
		idle_en = idle;
		if (hold)
			hold_req = 1'b1;
		repeat (items) random_press(good_pct);
	endtask

	initial begin
		sb = new();
		idle_en = 1'b1;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		press_valid = 1'b0;
		press_item = '0;
		pixel_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window: presses in the boot window and at exactly the window are dropped.
		send_press(REQ_INC, 32'd0);
		send_press(REQ_INC, 32'd200);
		send_press(REQ_INC, 32'd201);
		send_press(REQ_DEC, 32'd300);
		send_press(REQ_DEC, 32'd402);
		send_press(REQ_DEC, 32'd700);
		// Walks up through the glyphs 1 to 9 and then presses increment at nine.
		for (int k = 1; k <= 10; k++)
			send_press(REQ_INC, 32'(700 + 300 * k));
		send_press(REQ_DEC, 32'hFFFF_FFF0);
		send_press(REQ_INC, 32'h0000_0100);

		// With the largest window nothing is ever kept.
		wait_frames_done();
		cfg_write_debounce(32'hFFFF_FFFF);
		send_press(REQ_INC, 32'h8000_0000);
		send_press(REQ_DEC, 32'hFFFF_FFFF);

		wait_frames_done();
		cfg_write_debounce(32'd0);
		send_press(REQ_INC, 32'h0000_0100);
		send_press(REQ_DEC, 32'h0000_0101);

		run_phase(DEBOUNCE_RESET, 15, 80, 1'b1, 1'b0);
		run_phase(32'd0, 15, 80, 1'b0, 1'b0);
		run_phase(32'($urandom_range(5000, 1)), 20, 90, 1'b1, 1'b1);
		run_phase($urandom(), 15, 80, 1'b1, 1'b0);
		run_phase(32'hFFFF_FFFF, 8, 80, 1'b1, 1'b0);
		run_phase(32'($urandom_range(300, 0)), 15, 75, 1'b1, 1'b0);

		wait_frames_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS debounced_digit_matrix_driver_core");
		end else begin
			$display("FAIL debounced_digit_matrix_driver_core");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/ddmd_pkg.sv
design/debounced_digit_matrix_driver_core.sv
tb/debounced_digit_matrix_driver_core_tb.sv
